@@ rtl/core/ffha_pkg.sv @@
// Shared types, constants and state codes of the first-fit heap allocator.
`default_nettype none
package ffha_pkg;

  localparam int HEAP_UNITS_DEF = 1024;
  localparam int MAX_AW         = 16;   // address bits for the largest heap
  localparam int MAX_NW         = 17;   // link bits, one more to hold the null link
  localparam int UW             = 13;   // rounded unit count of a 16-bit byte count
  localparam int UNIT_BYTES     = 16;
  localparam int UNIT_ROUND     = 15;

  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_NOFIT = 2'd1,
    STAT_ZERO  = 2'd2
  } status_t;

  typedef enum logic [4:0] {
    ST_INIT,
    ST_IDLE,
    ST_A_RD,
    ST_A_CHK,
    ST_A_UNL,
    ST_A_S1,
    ST_A_S2,
    ST_F_RD,
    ST_F_CHK,
    ST_F_LRD,
    ST_F_LCHK,
    ST_F_LUNL,
    ST_F_RRD,
    ST_F_RCHK,
    ST_F_RUNL,
    ST_F_P1,
    ST_F_P2,
    ST_RESP
  } state_t;

  typedef struct packed {
    logic [MAX_AW-1:0] rd_addr;
    logic              bu_we;
    logic [MAX_AW-1:0] bu_wa;
    logic [MAX_AW-1:0] bu_wd;
    logic              fm_we;
    logic [MAX_AW-1:0] fm_wa;
    logic              fm_wd;
    logic              nx_we;
    logic [MAX_AW-1:0] nx_wa;
    logic [MAX_NW-1:0] nx_wd;
    logic              pv_we;
    logic [MAX_AW-1:0] pv_wa;
    logic [MAX_NW-1:0] pv_wd;
  } mem_cmd_t;

  typedef struct packed {
    logic [MAX_AW-1:0] bu;
    logic              fm;
    logic [MAX_NW-1:0] nx;
    logic [MAX_NW-1:0] pv;
  } mem_rd_t;

endpackage
`default_nettype wire

@@ rtl/core/ffha_store.sv @@
// Header store: block sizes, free marks and list links, one registered read port.
`default_nettype none
module ffha_store #(
  parameter int HEAP_UNITS = ffha_pkg::HEAP_UNITS_DEF
) (
  input  wire                     clk,
  input  wire ffha_pkg::mem_cmd_t cmd,
  output ffha_pkg::mem_rd_t       rdata
);
  import ffha_pkg::*;

  localparam int AW = $clog2(HEAP_UNITS);
  localparam int NW = AW + 1;

  logic [AW-1:0] bu_mem [HEAP_UNITS];
  logic          fm_mem [HEAP_UNITS];
  logic [NW-1:0] nx_mem [HEAP_UNITS];
  logic [NW-1:0] pv_mem [HEAP_UNITS];

  logic [AW-1:0] bu_q;
  logic          fm_q;
  logic [NW-1:0] nx_q;
  logic [NW-1:0] pv_q;

  always_ff @(posedge clk) begin
    if (cmd.bu_we) begin
      bu_mem[cmd.bu_wa[AW-1:0]] <= cmd.bu_wd[AW-1:0];
    end
    if (cmd.fm_we) begin
      fm_mem[cmd.fm_wa[AW-1:0]] <= cmd.fm_wd;
    end
    if (cmd.nx_we) begin
      nx_mem[cmd.nx_wa[AW-1:0]] <= cmd.nx_wd[NW-1:0];
    end
    if (cmd.pv_we) begin
      pv_mem[cmd.pv_wa[AW-1:0]] <= cmd.pv_wd[NW-1:0];
    end
    bu_q <= bu_mem[cmd.rd_addr[AW-1:0]];
    fm_q <= fm_mem[cmd.rd_addr[AW-1:0]];
    nx_q <= nx_mem[cmd.rd_addr[AW-1:0]];
    pv_q <= pv_mem[cmd.rd_addr[AW-1:0]];
  end

  assign rdata.bu = MAX_AW'(bu_q);
  assign rdata.fm = fm_q;
  assign rdata.nx = MAX_NW'(nx_q);
  assign rdata.pv = MAX_NW'(pv_q);

endmodule
`default_nettype wire

@@ rtl/core/ffha_ctrl.sv @@
// Request sequencer: list walk, header walk, split, unlink, merge and push.
`default_nettype none
module ffha_ctrl #(
  parameter int HEAP_UNITS = ffha_pkg::HEAP_UNITS_DEF
) (
  input  wire                     clk,
  input  wire                     rst,
  input  wire                     in_valid,
  output logic                    in_ready,
  input  wire                     req_type,
  input  wire  [15:0]             size_bytes,
  input  wire  [9:0]              block_offset,
  output logic                    out_valid,
  input  wire                     out_ready,
  output logic [1:0]              status,
  output logic [9:0]              data_offset,
  output ffha_pkg::mem_cmd_t      cmd,
  input  wire ffha_pkg::mem_rd_t  rdata
);
  import ffha_pkg::*;

  localparam int AW = $clog2(HEAP_UNITS);
  localparam int NW = AW + 1;
  localparam int CW = ((AW > UW) ? AW : UW) + 2;
  localparam logic [NW-1:0] NIL = NW'(HEAP_UNITS);

  state_t        state, state_next;
  logic [NW-1:0] head;
  logic          rtype;
  logic [UW-1:0] units;
  logic [NW-1:0] b, nx_b, pv_b, steps, cur, left, h, right;
  logic [AW-1:0] bu_b, bu_h;
  logic          split;

  logic          acc;
  logic [AW-1:0] rd_bu;
  logic          fit, split_w, off_bad;
  logic [NW-1:0] r_w, cur_nx, right_w;

  assign acc     = in_valid && in_ready;
  assign in_ready = (state == ST_IDLE) && !out_valid;
  assign rd_bu   = rdata.bu[AW-1:0];
  assign fit     = rdata.fm && (CW'(rd_bu) >= CW'(units));
  assign split_w = CW'(rd_bu) > (CW'(units) + CW'(1));
  assign r_w     = NW'(CW'(b) + CW'(units) + CW'(1));
  assign cur_nx  = NW'(CW'(cur) + CW'(rd_bu) + CW'(1));
  assign right_w = NW'(CW'(h) + CW'(bu_h) + CW'(1));
  assign off_bad = (block_offset == 10'd0) ||
                   (MAX_NW'(block_offset) > MAX_NW'(HEAP_UNITS));

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_INIT: state_next = ST_IDLE;
      ST_IDLE: begin
        if (acc) begin
          if (req_type == REQ_ALLOC) begin
            state_next = (size_bytes == 16'd0) ? ST_RESP : ST_A_RD;
          end else begin
            state_next = off_bad ? ST_RESP : ST_F_RD;
          end
        end
      end
      ST_A_RD:   state_next = (steps == NIL || b >= NIL) ? ST_RESP : ST_A_CHK;
      ST_A_CHK: begin
        if (fit) begin
          state_next = split_w ? ST_A_S1 : ST_A_UNL;
        end else begin
          state_next = ST_A_RD;
        end
      end
      ST_A_UNL:  state_next = ST_RESP;
      ST_A_S1:   state_next = ST_A_S2;
      ST_A_S2:   state_next = ST_RESP;
      ST_F_RD:   state_next = (cur >= NIL || cur > h) ? ST_RESP : ST_F_CHK;
      ST_F_CHK: begin
        if (cur != h) begin
          state_next = ST_F_RD;
        end else if (rdata.fm) begin
          state_next = ST_RESP;
        end else begin
          state_next = (left < NIL) ? ST_F_LRD : ST_F_RRD;
        end
      end
      ST_F_LRD:  state_next = ST_F_LCHK;
      ST_F_LCHK: state_next = rdata.fm ? ST_F_LUNL : ST_F_RRD;
      ST_F_LUNL: state_next = ST_F_RRD;
      ST_F_RRD:  state_next = (right_w < NIL) ? ST_F_RCHK : ST_F_P1;
      ST_F_RCHK: state_next = rdata.fm ? ST_F_RUNL : ST_F_P1;
      ST_F_RUNL: state_next = ST_F_P1;
      ST_F_P1:   state_next = ST_F_P2;
      ST_F_P2:   state_next = ST_RESP;
      ST_RESP:   state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // Store commands.
  always_comb begin
    cmd = '0;
    case (state)
      ST_INIT: begin
        cmd.bu_we = 1'b1;
        cmd.bu_wd = MAX_AW'(HEAP_UNITS - 1);
        cmd.fm_we = 1'b1;
        cmd.fm_wd = 1'b1;
        cmd.nx_we = 1'b1;
        cmd.nx_wd = MAX_NW'(NIL);
        cmd.pv_we = 1'b1;
        cmd.pv_wd = MAX_NW'(NIL);
      end
      ST_A_RD:  cmd.rd_addr = MAX_AW'(b[AW-1:0]);
      ST_F_RD:  cmd.rd_addr = MAX_AW'(cur[AW-1:0]);
      ST_F_LRD: cmd.rd_addr = MAX_AW'(left[AW-1:0]);
      ST_F_RRD: cmd.rd_addr = MAX_AW'(right_w[AW-1:0]);
      ST_A_UNL, ST_F_LUNL, ST_F_RUNL: begin
        cmd.nx_we = pv_b < NIL;
        cmd.nx_wa = MAX_AW'(pv_b[AW-1:0]);
        cmd.nx_wd = MAX_NW'(nx_b);
        cmd.pv_we = nx_b < NIL;
        cmd.pv_wa = MAX_AW'(nx_b[AW-1:0]);
        cmd.pv_wd = MAX_NW'(pv_b);
        cmd.fm_we = (state != ST_F_LUNL);
        cmd.fm_wa = (state == ST_A_UNL) ? MAX_AW'(b[AW-1:0]) : MAX_AW'(right[AW-1:0]);
        cmd.fm_wd = 1'b0;
      end
      ST_A_S1: begin
        cmd.bu_we = 1'b1;
        cmd.bu_wa = MAX_AW'(r_w[AW-1:0]);
        cmd.bu_wd = MAX_AW'(AW'(CW'(bu_b) - CW'(units) - CW'(1)));
        cmd.fm_we = 1'b1;
        cmd.fm_wa = MAX_AW'(r_w[AW-1:0]);
        cmd.fm_wd = 1'b1;
        cmd.nx_we = 1'b1;
        cmd.nx_wa = MAX_AW'(r_w[AW-1:0]);
        cmd.nx_wd = MAX_NW'(nx_b);
        cmd.pv_we = 1'b1;
        cmd.pv_wa = MAX_AW'(r_w[AW-1:0]);
        cmd.pv_wd = MAX_NW'(pv_b);
      end
      ST_A_S2: begin
        cmd.nx_we = pv_b < NIL;
        cmd.nx_wa = MAX_AW'(pv_b[AW-1:0]);
        cmd.nx_wd = MAX_NW'(r_w);
        cmd.pv_we = nx_b < NIL;
        cmd.pv_wa = MAX_AW'(nx_b[AW-1:0]);
        cmd.pv_wd = MAX_NW'(r_w);
        cmd.bu_we = 1'b1;
        cmd.bu_wa = MAX_AW'(b[AW-1:0]);
        cmd.bu_wd = MAX_AW'(AW'(units));
        cmd.fm_we = 1'b1;
        cmd.fm_wa = MAX_AW'(b[AW-1:0]);
        cmd.fm_wd = 1'b0;
      end
      ST_F_P1: begin
        cmd.bu_we = 1'b1;
        cmd.bu_wa = MAX_AW'(h[AW-1:0]);
        cmd.bu_wd = MAX_AW'(bu_h);
        cmd.fm_we = 1'b1;
        cmd.fm_wa = MAX_AW'(h[AW-1:0]);
        cmd.fm_wd = 1'b1;
        cmd.nx_we = 1'b1;
        cmd.nx_wa = MAX_AW'(h[AW-1:0]);
        cmd.nx_wd = MAX_NW'(head);
        cmd.pv_we = 1'b1;
        cmd.pv_wa = MAX_AW'(h[AW-1:0]);
        cmd.pv_wd = MAX_NW'(NIL);
      end
      ST_F_P2: begin
        cmd.pv_we = head < NIL;
        cmd.pv_wa = MAX_AW'(head[AW-1:0]);
        cmd.pv_wd = MAX_NW'(h);
      end
      default: cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_INIT;
      head      <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (acc) begin
            rtype       <= req_type;
            units       <= UW'((17'(size_bytes) + 17'(UNIT_ROUND)) / UNIT_BYTES);
            status      <= (req_type == REQ_ALLOC && size_bytes == 16'd0) ? STAT_ZERO : STAT_OK;
            data_offset <= '0;
            b           <= head;
            steps       <= '0;
            cur         <= '0;
            left        <= NIL;
            h           <= NW'(block_offset - 10'd1);
          end
        end
        ST_A_RD: begin
          if (steps == NIL || b >= NIL) begin
            status <= STAT_NOFIT;
          end
        end
        ST_A_CHK: begin
          if (fit) begin
            bu_b        <= rd_bu;
            nx_b        <= rdata.nx[NW-1:0];
            pv_b        <= rdata.pv[NW-1:0];
            split       <= split_w;
            data_offset <= 10'(MAX_NW'(b) + MAX_NW'(1));
          end else begin
            b     <= rdata.nx[NW-1:0];
            steps <= steps + NW'(1);
          end
        end
        ST_A_S2, ST_A_UNL: begin
          if (pv_b >= NIL) begin
            head <= split ? r_w : nx_b;
          end
        end
        ST_F_CHK: begin
          if (cur != h) begin
            left <= cur;
            cur  <= cur_nx;
          end else begin
            bu_h <= rd_bu;
          end
        end
        ST_F_LCHK: begin
          bu_b <= rd_bu;
          nx_b <= rdata.nx[NW-1:0];
          pv_b <= rdata.pv[NW-1:0];
        end
        ST_F_LUNL: begin
          if (pv_b >= NIL) begin
            head <= nx_b;
          end
          bu_h <= AW'(CW'(bu_b) + CW'(bu_h) + CW'(1));
          h    <= left;
        end
        ST_F_RRD: right <= right_w;
        ST_F_RCHK: begin
          nx_b <= rdata.nx[NW-1:0];
          pv_b <= rdata.pv[NW-1:0];
          if (rdata.fm) begin
            bu_h <= AW'(CW'(bu_h) + CW'(rd_bu) + CW'(1));
          end
        end
        ST_F_RUNL: begin
          if (pv_b >= NIL) begin
            head <= nx_b;
          end
        end
        ST_F_P2: head <= h;
        ST_RESP: out_valid <= 1'b1;
        default: ;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_no_accept_while_busy: assert property (@(posedge clk) disable iff (rst)
    !(acc && out_valid)) else $error("request accepted while a response waits");
  a_walk_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_A_CHK) |-> (b < NIL)) else $error("list walk read past null link");
  a_resp_valid: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RESP) |=> out_valid) else $error("response not raised");
  a_free_ok: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RESP && rtype == REQ_FREE) |-> (status == STAT_OK && data_offset == 10'd0))
    else $error("free response not plain ok");
`endif

endmodule
`default_nettype wire

@@ rtl/core/first_fit_heap_allocator.sv @@
// Top level of the first-fit heap allocator with coalescing.
// Allocate: walks the free list node by node from its head, and every list step goes
// through the single read port of the header store.
// Free: walks every block header below the freed one, then merges free neighbours.
// One request is in work at a time; the next is taken after its response leaves.
// Synchronous reset, then an init state that writes the header of the whole-heap block.
`default_nettype none
module first_fit_heap_allocator #(
  parameter int HEAP_UNITS = ffha_pkg::HEAP_UNITS_DEF
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         s_tvalid,
  output logic        s_tready,
  input  wire  [31:0] s_tdata,   // size_bytes[15:0], block_offset[25:16], zeros above
  input  wire  [0:0]  s_tuser,   // req_type[0]
  output logic        m_tvalid,
  input  wire         m_tready,
  output logic [15:0] m_tdata    // status[1:0], data_offset[11:2], zeros above
);
  import ffha_pkg::*;

  mem_cmd_t    cmd;
  mem_rd_t     rdata;
  logic [1:0]  status;
  logic [9:0]  data_offset;

  ffha_ctrl #(.HEAP_UNITS(HEAP_UNITS)) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (s_tvalid),
    .in_ready     (s_tready),
    .req_type     (s_tuser[0]),
    .size_bytes   (s_tdata[15:0]),
    .block_offset (s_tdata[25:16]),
    .out_valid    (m_tvalid),
    .out_ready    (m_tready),
    .status       (status),
    .data_offset  (data_offset),
    .cmd          (cmd),
    .rdata        (rdata)
  );

  ffha_store #(.HEAP_UNITS(HEAP_UNITS)) u_store (
    .clk   (clk),
    .cmd   (cmd),
    .rdata (rdata)
  );

  assign m_tdata = {4'd0, data_offset, status};

endmodule
`default_nettype wire
